/* design/assert_macros.svh */
// Assertion helpers included by the top-level allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`define ASSERT_LATER2(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define ASSERT_LATER2(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/fcpa_pkg.sv */
package fcpa_pkg;

    localparam int HANDLE_W     = 10;
    localparam int LIMIT_W      = 11;
    localparam int COUNT_W      = 11;
    localparam int SIZE_W       = 16;
    localparam int CPB_W        = 9;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 16;

    localparam logic [LIMIT_W-1:0] HANDLE_SPACE = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 11'd2047;

    localparam logic [SIZE_W-1:0] CHUNK_SIZE_RESET = 16'd64;
    localparam logic [CPB_W-1:0]  CPB_RESET        = 9'd256;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHUNKS_PER  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_RESIZE = 2'd2;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_code_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_LARGE = 2'd1,
        STATUS_NO_MEMORY = 2'd2,
        STATUS_BAD_FREE  = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } fcpa_cmd_t;

endpackage

/* design/fcpa_ctrl.sv */
module fcpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output fcpa_pkg::fcpa_cmd_t cmd
);
    import fcpa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    assign cmd.capture = accept;
    assign cmd.execute = (state_reg == ST_EXEC);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (state_reg == ST_EXEC) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

/* design/fcpa_datapath.sv */
module fcpa_datapath #(
    parameter int MAX_CHUNKS_PER_BLOCK = 256,
    parameter int MAX_BLOCKS           = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  fcpa_pkg::fcpa_cmd_t                   cmd,
    input  logic                                  cfg_we,
    input  logic [fcpa_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fcpa_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_command,
    input  logic [fcpa_pkg::SIZE_W-1:0]           in_request_bytes,
    input  logic [fcpa_pkg::HANDLE_W-1:0]         in_free_chunk,
    output logic [fcpa_pkg::HANDLE_W-1:0]         out_chunk_index,
    output fcpa_pkg::status_t                     out_status
);
    import fcpa_pkg::*;

    localparam int BLK_W     = $clog2(MAX_BLOCKS + 1);
    localparam int MCPB_W    = $clog2(MAX_CHUNKS_PER_BLOCK + 1) + 1;
    localparam int CMP_W     = (MCPB_W > CPB_W) ? MCPB_W : CPB_W;
    localparam int RESET_CPB = (MAX_CHUNKS_PER_BLOCK < 256) ? MAX_CHUNKS_PER_BLOCK : 256;
    localparam int DEPTH     = 1 << HANDLE_W;

    localparam logic [BLK_W-1:0]   MAX_BLOCKS_C = BLK_W'(MAX_BLOCKS);
    localparam logic [CMP_W-1:0]   MAX_CPB_C    = CMP_W'(MAX_CHUNKS_PER_BLOCK);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(RESET_CPB);

    logic [HANDLE_W-1:0] link_mem [DEPTH];
    logic [HANDLE_W-1:0] rd_data_reg;

    logic [SIZE_W-1:0]   chunk_size_reg;
    logic [CPB_W-1:0]    cpb_reg;
    logic                auto_reg;

    logic                cmd_reg;
    logic [SIZE_W-1:0]   req_reg;
    logic [HANDLE_W-1:0] free_reg;

    logic [HANDLE_W-1:0] head_reg, head_next;
    logic                valid_reg, valid_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [LIMIT_W-1:0]  fresh_reg, fresh_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [BLK_W-1:0]    blocks_reg, blocks_next;
    logic [HANDLE_W-1:0] index_reg, index_next;
    status_t             status_reg, status_next;

    logic [CPB_W-1:0]    cpb_src;
    logic [CPB_W-1:0]    cpb_fix;
    logic [CPB_W-1:0]    block_chunks;
    logic [LIMIT_W:0]    grown_sum;
    logic [LIMIT_W-1:0]  grown_limit;
    logic [LIMIT_W-1:0]  limit_eff;
    logic [COUNT_W-1:0]  count_dec;
    logic                grow;
    logic                push_ok;

    // block size for the value in force, or the one being written
    assign cpb_src = (cfg_we && cfg_index == CFG_CHUNKS_PER) ? cfg_data[CPB_W-1:0] : cpb_reg;
    assign cpb_fix = (cpb_src == '0) ? CPB_W'(1) : cpb_src;
    assign block_chunks = (CMP_W'(cpb_fix) > MAX_CPB_C) ? CPB_W'(MAX_CHUNKS_PER_BLOCK) : cpb_fix;

    assign grown_sum   = {1'b0, limit_reg} + (LIMIT_W + 1)'(block_chunks);
    assign grown_limit = (grown_sum > (LIMIT_W + 1)'(HANDLE_SPACE)) ? HANDLE_SPACE
                                                                  : grown_sum[LIMIT_W-1:0];

    assign grow = (fresh_reg >= limit_reg) && auto_reg && (blocks_reg < MAX_BLOCKS_C)
               && (limit_reg < HANDLE_SPACE);
    assign limit_eff = grow ? grown_limit : limit_reg;
    assign count_dec = count_reg - COUNT_W'(1);
    assign push_ok   = (LIMIT_W'(free_reg) < fresh_reg);

    always_comb begin
        head_next   = head_reg;
        valid_next  = valid_reg;
        count_next  = count_reg;
        fresh_next  = fresh_reg;
        limit_next  = limit_reg;
        blocks_next = blocks_reg;
        index_next  = index_reg;
        status_next = status_reg;
        if (cmd.execute) begin
            index_next  = '0;
            status_next = STATUS_OK;
            if (cmd_reg == CMD_FREE) begin
                index_next = free_reg;
                if (!push_ok) begin
                    status_next = STATUS_BAD_FREE;
                end else begin
                    head_next  = free_reg;
                    valid_next = 1'b1;
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            end else if (req_reg > chunk_size_reg) begin
                status_next = STATUS_TOO_LARGE;
            end else if (valid_reg) begin
                index_next = head_reg;
                count_next = count_dec;
                if (count_dec == '0) begin
                    valid_next = 1'b0;
                end else begin
                    head_next = rd_data_reg;
                end
            end else begin
                if (grow) begin
                    blocks_next = blocks_reg + BLK_W'(1);
                    limit_next  = grown_limit;
                end
                if (fresh_reg < limit_eff) begin
                    index_next = fresh_reg[HANDLE_W-1:0];
                    fresh_next = fresh_reg + LIMIT_W'(1);
                end else begin
                    status_next = STATUS_NO_MEMORY;
                end
            end
        end else if (cfg_we && cfg_index == CFG_CHUNKS_PER && fresh_reg == '0
                     && blocks_reg == BLK_W'(1)) begin
            limit_next = LIMIT_W'(block_chunks);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg <= CHUNK_SIZE_RESET;
            cpb_reg        <= CPB_RESET;
            auto_reg       <= 1'b0;
            head_reg       <= '0;
            valid_reg      <= 1'b0;
            count_reg      <= '0;
            fresh_reg      <= '0;
            limit_reg      <= LIMIT_RESET;
            blocks_reg     <= BLK_W'(1);
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CHUNK_SIZE:  chunk_size_reg <= cfg_data[SIZE_W-1:0];
                    CFG_CHUNKS_PER:  cpb_reg        <= cfg_data[CPB_W-1:0];
                    CFG_AUTO_RESIZE: auto_reg       <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            head_reg   <= head_next;
            valid_reg  <= valid_next;
            count_reg  <= count_next;
            fresh_reg  <= fresh_next;
            limit_reg  <= limit_next;
            blocks_reg <= blocks_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg  <= in_command;
            req_reg  <= in_request_bytes;
            free_reg <= in_free_chunk;
        end
        index_reg  <= index_next;
        status_reg <= status_next;
    end

    // link store: push writes the old head, read port follows the head
    always_ff @(posedge aclk) begin
        if (cmd.execute && cmd_reg == CMD_FREE && push_ok) begin
            link_mem[free_reg] <= head_reg;
        end
        rd_data_reg <= link_mem[head_reg];
    end

    assign out_chunk_index = index_reg;
    assign out_status      = status_reg;

endmodule

/* design/fixed_chunk_pool_allocator.sv */
// Fixed-size chunk pool allocator with a LIFO free list and lazy fresh chunks.
// An accepted item is captured, executed in the EXEC state and its result registered;
// no new item is taken until the FSM is back in IDLE and the output is free or read,
// which gives the registered link-store read time to yield the next free-list head.
// Reset: synchronous, active low; free list empty, one block open, no clearing pass.
`include "assert_macros.svh"

module fixed_chunk_pool_allocator #(
    parameter int MAX_CHUNKS_PER_BLOCK = 256,
    parameter int MAX_BLOCKS           = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [fcpa_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fcpa_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [fcpa_pkg::S_TDATA_W-1:0]        s_tdata,  // request_bytes, free_chunk
    input  logic                                  s_tuser,  // command
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [fcpa_pkg::M_TDATA_W-1:0]        m_tdata,  // chunk_index
    output logic [1:0]                            m_tuser   // status
);
    import fcpa_pkg::*;

    fcpa_cmd_t           cmd;
    logic [HANDLE_W-1:0] out_index;
    status_t             out_status;

    fcpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fcpa_datapath #(
        .MAX_CHUNKS_PER_BLOCK (MAX_CHUNKS_PER_BLOCK),
        .MAX_BLOCKS           (MAX_BLOCKS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_command       (s_tuser),
        .in_request_bytes (s_tdata[SIZE_W-1:0]),
        .in_free_chunk    (s_tdata[SIZE_W+HANDLE_W-1:SIZE_W]),
        .out_chunk_index  (out_index),
        .out_status       (out_status)
    );

    assign m_tdata = {{(M_TDATA_W - HANDLE_W){1'b0}}, out_index};
    assign m_tuser = out_status;

    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "item accepted while busy")
    `ASSERT_LATER2(a_result_follows, aclk, aresetn, s_tvalid && s_tready, m_tvalid, "result missing two cycles after accept")
    `ASSERT_SAME(a_fail_index_zero, aclk, aresetn, m_tvalid && (m_tuser == STATUS_TOO_LARGE || m_tuser == STATUS_NO_MEMORY), m_tdata == '0, "failed allocate returned nonzero index")
    `ASSERT_SAME(a_tdata_pad, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_W-1:HANDLE_W] == '0, "padding bits set")

endmodule
